FILE: hdl/rau_pkg.sv
// Shared types, codes and helpers for the rational arithmetic unit.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
    localparam int NUM_WIDTH     = 33;
    localparam int DEN_WIDTH     = 32;
    localparam int MAG_WIDTH     = 32;
    localparam int DIV_STEPS     = MAG_WIDTH;
    localparam int CNT_WIDTH     = $clog2(DIV_STEPS);

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_SUB    = 3'd1;
    localparam logic [2:0] ACT_MUL    = 3'd2;
    localparam logic [2:0] ACT_DIV    = 3'd3;
    localparam logic [2:0] ACT_REDUCE = 3'd4;

    // Operand pair routed to the shared divider.
    typedef enum logic [1:0] {
        SRC_GCD = 2'd0,
        SRC_NUM = 2'd1,
        SRC_DEN = 2'd2
    } rau_src_t;

    typedef struct packed {
        logic [2:0]                      action;
        logic signed [OPERAND_WIDTH-1:0] a_num;
        logic signed [OPERAND_WIDTH-1:0] a_den;
        logic signed [OPERAND_WIDTH-1:0] b_num;
        logic signed [OPERAND_WIDTH-1:0] b_den;
    } rau_req_t;

    typedef struct packed {
        logic signed [NUM_WIDTH-1:0] res_num;
        logic signed [DEN_WIDTH-1:0] res_den;
        logic                        error;
    } rau_rsp_t;

    typedef struct packed {
        logic     load;
        logic     mul0;
        logic     mul1;
        logic     mul2;
        logic     gcd_init;
        logic     div_start;
        rau_src_t div_src;
        logic     gcd_step;
        logic     save_num;
        logic     save_den;
        logic     set_err;
    } rau_cmd_t;

    typedef struct packed {
        logic act_bad;
        logic x_zero;
        logic y_zero;
        logic div_done;
    } rau_sts_t;

    // Magnitude of a signed value known to lie within +/- 2^31.
    function automatic logic [MAG_WIDTH-1:0] mag(input logic signed [NUM_WIDTH-1:0] v);
        logic [NUM_WIDTH-1:0] t;
        t = v[NUM_WIDTH-1] ? (~v + NUM_WIDTH'(1)) : v;
        return t[MAG_WIDTH-1:0];
    endfunction

endpackage

FILE: hdl/rau_divider.sv
// Shared restoring divider with truncating signed quotient and remainder.
// Depends on rau_pkg for widths and the magnitude helper.
module rau_divider (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [rau_pkg::NUM_WIDTH-1:0]  dividend,
    input  logic signed [rau_pkg::NUM_WIDTH-1:0]  divisor,
    output logic                                  busy,
    output logic                                  done,
    output logic signed [rau_pkg::NUM_WIDTH-1:0]  quotient,
    output logic signed [rau_pkg::NUM_WIDTH-1:0]  remainder
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [rau_pkg::CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [rau_pkg::MAG_WIDTH-1:0]   quo_reg, quo_next;
    logic [rau_pkg::MAG_WIDTH-1:0]   rem_reg, rem_next;
    logic [rau_pkg::MAG_WIDTH-1:0]   dsr_reg, dsr_next;
    logic                            neg_q_reg, neg_q_next;
    logic                            neg_r_reg, neg_r_next;
    logic [rau_pkg::MAG_WIDTH:0]     trial;
    logic [rau_pkg::MAG_WIDTH:0]     diff;
    logic [rau_pkg::NUM_WIDTH-1:0]   q_ext;
    logic [rau_pkg::NUM_WIDTH-1:0]   r_ext;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        trial      = {rem_reg, quo_reg[rau_pkg::MAG_WIDTH-1]};
        diff       = trial - {1'b0, dsr_reg};
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            quo_next   = rau_pkg::mag(dividend);
            rem_next   = '0;
            dsr_next   = rau_pkg::mag(divisor);
            neg_q_next = dividend[rau_pkg::NUM_WIDTH-1] ^ divisor[rau_pkg::NUM_WIDTH-1];
            neg_r_next = dividend[rau_pkg::NUM_WIDTH-1];
        end
        else if (busy_reg)
        begin
            // One quotient bit per cycle; the partial remainder never reaches the divisor.
            rem_next = diff[rau_pkg::MAG_WIDTH] ? trial[rau_pkg::MAG_WIDTH-1:0]
                                                : diff[rau_pkg::MAG_WIDTH-1:0];
            quo_next = {quo_reg[rau_pkg::MAG_WIDTH-2:0], ~diff[rau_pkg::MAG_WIDTH]};
            cnt_next = cnt_reg + rau_pkg::CNT_WIDTH'(1);
            if (cnt_reg == rau_pkg::CNT_WIDTH'(rau_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign q_ext     = {1'b0, quo_reg};
    assign r_ext     = {1'b0, rem_reg};
    assign quotient  = $signed(neg_q_reg ? (~q_ext + rau_pkg::NUM_WIDTH'(1)) : q_ext);
    assign remainder = $signed(neg_r_reg ? (~r_ext + rau_pkg::NUM_WIDTH'(1)) : r_ext);
    assign busy      = busy_reg;
    assign done      = done_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

FILE: hdl/rau_datapath.sv
// Datapath: operand latch, shared 16x16 multiplier, Euclid registers and result register.
// Depends on rau_pkg and instantiates rau_divider.
module rau_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  rau_pkg::rau_req_t  req,
    input  rau_pkg::rau_cmd_t  cmd,
    output rau_pkg::rau_sts_t  sts,
    output rau_pkg::rau_rsp_t  rsp
);

    rau_pkg::rau_req_t                       req_reg;
    rau_pkg::rau_rsp_t                       rsp_reg;
    logic signed [rau_pkg::PROD_WIDTH-1:0]   t0_reg;
    logic signed [rau_pkg::NUM_WIDTH-1:0]    n_reg;
    logic signed [rau_pkg::NUM_WIDTH-1:0]    d_reg;
    logic signed [rau_pkg::NUM_WIDTH-1:0]    x_reg;
    logic signed [rau_pkg::NUM_WIDTH-1:0]    y_reg;

    logic signed [rau_pkg::OPERAND_WIDTH-1:0] mul_a;
    logic signed [rau_pkg::OPERAND_WIDTH-1:0] mul_b;
    logic signed [rau_pkg::PROD_WIDTH-1:0]    prod;
    logic signed [rau_pkg::NUM_WIDTH-1:0]     n_next;
    logic signed [rau_pkg::NUM_WIDTH-1:0]     d_next;
    logic signed [rau_pkg::NUM_WIDTH-1:0]     div_dvd;
    logic signed [rau_pkg::NUM_WIDTH-1:0]     div_dsr;
    logic signed [rau_pkg::NUM_WIDTH-1:0]     div_quo;
    logic signed [rau_pkg::NUM_WIDTH-1:0]     div_rem;
    logic                                     div_busy;
    logic                                     div_done;

    // Product order: step 0 gives the first numerator term (the whole numerator for mul
    // and div), step 1 the second (add and sub only), step 2 the denominator; reduce uses a.
    always_comb
    begin
        mul_a = req_reg.a_num;
        mul_b = req_reg.b_den;
        if (cmd.mul0)
        begin
            mul_a = req_reg.a_num;
            mul_b = (req_reg.action == rau_pkg::ACT_MUL) ? req_reg.b_num : req_reg.b_den;
        end
        else if (cmd.mul1)
        begin
            mul_a = req_reg.b_num;
            mul_b = req_reg.a_den;
        end
        else if (cmd.mul2)
        begin
            mul_a = req_reg.a_den;
            mul_b = (req_reg.action == rau_pkg::ACT_DIV) ? req_reg.b_num : req_reg.b_den;
        end
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        unique case (req_reg.action)
            rau_pkg::ACT_ADD:
                n_next = rau_pkg::NUM_WIDTH'(t0_reg) + rau_pkg::NUM_WIDTH'(prod);
            rau_pkg::ACT_SUB:
                n_next = rau_pkg::NUM_WIDTH'(t0_reg) - rau_pkg::NUM_WIDTH'(prod);
            rau_pkg::ACT_MUL, rau_pkg::ACT_DIV:
                n_next = rau_pkg::NUM_WIDTH'(t0_reg);
            rau_pkg::ACT_REDUCE:
                n_next = rau_pkg::NUM_WIDTH'(req_reg.a_num);
            default:
                n_next = '0;
        endcase
        d_next = (req_reg.action == rau_pkg::ACT_REDUCE) ? rau_pkg::NUM_WIDTH'(req_reg.a_den)
                                                         : rau_pkg::NUM_WIDTH'(prod);
    end

    always_comb
    begin
        case (cmd.div_src)
            rau_pkg::SRC_GCD:
            begin
                div_dvd = x_reg;
                div_dsr = y_reg;
            end
            rau_pkg::SRC_NUM:
            begin
                div_dvd = n_reg;
                div_dsr = x_reg;
            end
            rau_pkg::SRC_DEN:
            begin
                div_dvd = d_reg;
                div_dsr = x_reg;
            end
            default:
            begin
                div_dvd = x_reg;
                div_dsr = y_reg;
            end
        endcase
    end

    rau_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.mul0)
        begin
            t0_reg <= prod;
        end
        if (cmd.mul1)
        begin
            n_reg <= n_next;
        end
        if (cmd.mul2)
        begin
            d_reg <= d_next;
        end
        // Once y reaches zero, x holds the divisor for the two final divisions.
        if (cmd.gcd_init)
        begin
            x_reg <= n_reg;
            y_reg <= d_reg;
        end
        else if (cmd.gcd_step)
        begin
            x_reg <= y_reg;
            y_reg <= div_rem;
        end
        if (cmd.set_err)
        begin
            rsp_reg.res_num <= '0;
            rsp_reg.res_den <= '0;
            rsp_reg.error   <= 1'b1;
        end
        else if (cmd.save_num)
        begin
            rsp_reg.res_num <= div_quo;
            rsp_reg.error   <= 1'b0;
        end
        else if (cmd.save_den)
        begin
            rsp_reg.res_den <= div_quo[rau_pkg::DEN_WIDTH-1:0];
        end
    end

    assign sts.act_bad  = req_reg.action > rau_pkg::ACT_REDUCE;
    assign sts.x_zero   = x_reg == '0;
    assign sts.y_zero   = y_reg == '0;
    assign sts.div_done = div_done;
    assign rsp          = rsp_reg;

    a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start && (cmd.div_src == rau_pkg::SRC_NUM || cmd.div_src == rau_pkg::SRC_DEN))
            |-> (x_reg != '0 && !div_busy))
        else $error("final division started with a zero divisor or a busy divider");

endmodule

FILE: hdl/rau_ctrl.sv
// Controller state machine: sequences multiply, Euclid and final divisions.
// Depends on rau_pkg for the command and status structs.
module rau_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rau_pkg::rau_sts_t  sts,
    output rau_pkg::rau_cmd_t  cmd,
    output logic               busy,
    output logic               done
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_GCD_INIT,
        ST_GCD_TEST,
        ST_DIV_GCD,
        ST_DIV_NUM,
        ST_DEN_START,
        ST_DIV_DEN
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   finish;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        finish     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                if (sts.act_bad)
                begin
                    cmd.set_err = 1'b1;
                    finish      = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.mul0   = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_GCD_INIT;
            end
            ST_GCD_INIT:
            begin
                cmd.gcd_init = 1'b1;
                state_next   = ST_GCD_TEST;
            end
            ST_GCD_TEST:
            begin
                if (sts.y_zero)
                begin
                    if (sts.x_zero)
                    begin
                        cmd.set_err = 1'b1;
                        finish      = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_src   = rau_pkg::SRC_NUM;
                        state_next    = ST_DIV_NUM;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = rau_pkg::SRC_GCD;
                    state_next    = ST_DIV_GCD;
                end
            end
            ST_DIV_GCD:
            begin
                if (sts.div_done)
                begin
                    cmd.gcd_step = 1'b1;
                    state_next   = ST_GCD_TEST;
                end
            end
            ST_DIV_NUM:
            begin
                if (sts.div_done)
                begin
                    cmd.save_num = 1'b1;
                    state_next   = ST_DEN_START;
                end
            end
            ST_DEN_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = rau_pkg::SRC_DEN;
                state_next    = ST_DIV_DEN;
            end
            ST_DIV_DEN:
            begin
                if (sts.div_done)
                begin
                    cmd.save_den = 1'b1;
                    finish       = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= state_next != ST_IDLE;
            done_reg  <= finish;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> (busy_reg && !done_reg))
        else $error("accepted request did not raise busy");

endmodule

FILE: hdl/rational_arith_unit.sv
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl, rau_datapath and rau_divider.
//
//  channel   signals            transfer
//  request   start, busy, req   taken at a clock edge with start high and busy low
//  result    done, rsp          rsp valid while done is high, for one cycle only
//
// A request passes MUL0, MUL1, MUL2, GCD_INIT and GCD_TEST, then per Euclid remainder
// step a DIV_GCD run and a return to GCD_TEST, then DIV_NUM, DEN_START and DIV_DEN; every
// remainder and both final divisions run one bit per cycle through the single shared
// 32-step divider. An unused action, or a zero numerator over a zero denominator, sets error.
// After reset the unit is idle and accepts a request at once; the receiver cannot
// stall, and a new request may be taken in the cycle that done is high.
module rational_arith_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rau_pkg::rau_req_t  req,
    output logic               busy,
    output logic               done,
    output rau_pkg::rau_rsp_t  rsp
);

    rau_pkg::rau_cmd_t cmd;
    rau_pkg::rau_sts_t sts;

    rau_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    rau_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule
